>>> src/orb_pkg.sv
// orb_pkg: shared types and constants for the orbit camera offset block.
// Holds the CORDIC arctangent table, fixed-point constants, state and struct types.
// Depends on nothing; every module of the block imports it.
package orb_pkg;

   // Fixed-point formats
   localparam int TRIG_W     = 32;            // Q2.30 sine / cosine
   localparam int CORDIC_W   = 34;            // CORDIC datapath, headroom over Q2.30
   localparam int PROD_W     = 64;            // shared multiplier product
   localparam int OFFSET_W   = 17;            // signed Q8.8 offset
   localparam int RADIUS_W   = 16;
   localparam int ELEV_W     = 15;            // elevation state, 0..32767
   localparam int ELEV_SUM_W = 18;            // elevation plus signed step
   localparam int STEP_IN_W  = 16;

   localparam logic signed [TRIG_W-1:0]   Q30_ONE      = 32'sh4000_0000;
   localparam logic signed [CORDIC_W-1:0] Q30_ONE_WIDE = 34'sh0_4000_0000;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [PROD_W-1:0]   ROUND_HALF   = 64'sd536870912;
   localparam logic signed [TRIG_W-1:0]   OFFSET_LIMIT = 32'sd65535;

   // Arctangent of 2^-i, 2^32 units per turn
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;
   localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORBIT_RADIUS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEVATION_MIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEVATION_MAX = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 16'd2560;
   localparam logic [ELEV_W-1:0]   ELEV_MIN_RESET = 15'd104;
   localparam logic [ELEV_W-1:0]   ELEV_MAX_RESET = 15'd16384;

   // Quarter-turn pre-rotation applied ahead of the CORDIC iterations
   typedef enum logic [1:0] {
      ROT_NONE,
      ROT_POS,
      ROT_NEG
   } rot_type;

   // Top-level sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AZ_GO,
      ST_AZ_WAIT,
      ST_EL_GO,
      ST_EL_WAIT,
      ST_MUL_SA,
      ST_MUL_RCE,
      ST_MUL_SCA,
      ST_MUL_RT1,
      ST_MUL_RT2,
      ST_FINISH
   } state_type;

   // CORDIC result bundle: done pulse with clamped Q2.30 cosine and sine
   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] cos_q;
      logic signed [TRIG_W-1:0] sin_q;
   } cordic_out_type;

endpackage

>>> src/orb_cordic.sv
// orb_cordic: iterative CORDIC in rotation mode, one micro-rotation per cycle.
// Produces clamped Q2.30 cosine and sine of a 32-bit binary angle.
// Depends on orb_pkg for the arctangent table, constants and result struct.
module orb_cordic import orb_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    turn,
   output cordic_out_type result
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   rot_type                    rot_ff, rot_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic signed [TRIG_W-1:0]   angle;
   logic signed [CORDIC_W-1:0] dx, dy, atan_val;
   logic signed [CORDIC_W-1:0] cos_raw, sin_raw;
   logic                       last_step;

   function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [CORDIC_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > Q30_ONE_WIDE) begin
         r = Q30_ONE;
      end else if (v < -Q30_ONE_WIDE) begin
         r = -Q30_ONE;
      end else begin
         r = TRIG_W'(v);
      end
      return r;
   endfunction

   assign angle     = signed'(turn);
   assign last_step = busy_ff && (step_ff == LAST_STEP);
   assign dx        = y_ff >>> step_ff;
   assign dy        = x_ff >>> step_ff;
   assign atan_val  = signed'({2'b00, ATAN_TURNS[ATAN_IDX_W'(step_ff)]});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      rot_in  = rot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = last_step;
      if (start) begin
         x_in    = CORDIC_START;
         y_in    = '0;
         step_in = '0;
         busy_in = 1'b1;
         // fold the angle into the right half plane
         if (angle > Q30_ONE) begin
            z_in   = CORDIC_W'(angle - Q30_ONE);
            rot_in = ROT_POS;
         end else if (angle < -Q30_ONE) begin
            z_in   = CORDIC_W'(angle + Q30_ONE);
            rot_in = ROT_NEG;
         end else begin
            z_in   = CORDIC_W'(angle);
            rot_in = ROT_NONE;
         end
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rot_ff  <= ROT_NONE;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rot_ff  <= rot_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // undo the quarter-turn fold
   always_comb begin
      case (rot_ff)
         ROT_POS: begin
            cos_raw = -y_ff;
            sin_raw = x_ff;
         end
         ROT_NEG: begin
            cos_raw = y_ff;
            sin_raw = -x_ff;
         end
         default: begin
            cos_raw = x_ff;
            sin_raw = y_ff;
         end
      endcase
   end

   assign result.done  = done_ff;
   assign result.cos_q = clamp_one(cos_raw);
   assign result.sin_q = clamp_one(sin_raw);

endmodule

>>> src/orbit_angle_to_offset.sv
// orbit_angle_to_offset: top level of the orbit camera offset block.
// Holds the angle state, configuration registers, sequencer and shared multiplier.
// Depends on orb_pkg and instantiates orb_cordic.

// Each accepted word carries an azimuth step and an elevation step in signed
// binary angle units (65536 per turn). The block advances its azimuth (the step
// flips sign while the camera is upside down), clamps the elevation between
// elevation_min and elevation_max, sets the up flag, and returns one result word
// with the camera offset radius*(sin e sin a, cos e, sin e cos a) in signed Q8.8,
// saturated to +-65535, plus the new up flag. Sine and cosine come from one
// iterative CORDIC unit, run once for the azimuth and once for the elevation,
// one micro-rotation per cycle; five products then go through one shared
// 32x32 multiplier, one per cycle. A new word is taken only once the last one
// has gone through the whole sequence: req_ready is high only while the
// sequencer idles. A finished result sits in the output register until taken,
// so the next word can be accepted while it waits. Configuration writes land
// at once and must be made only while no item is in flight.
module orbit_angle_to_offset import orb_pkg::*; #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [STEP_IN_W-1:0] req_azimuth_step,
   input  logic signed [STEP_IN_W-1:0] req_elevation_step,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OFFSET_W-1:0]  rsp_offset_x,
   output logic signed [OFFSET_W-1:0]  rsp_offset_y,
   output logic signed [OFFSET_W-1:0]  rsp_offset_z,
   output logic                        rsp_is_upright,
   // configuration port
   input  logic                        csr_write,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [RADIUS_W-1:0]         csr_wdata
);

   localparam int LSHIFT = (ANGLE_BITS >= STEP_IN_W) ? ANGLE_BITS - STEP_IN_W : 0;
   localparam int RSHIFT = (ANGLE_BITS <  STEP_IN_W) ? STEP_IN_W - ANGLE_BITS : 0;
   localparam int AZ_PAD = 32 - ANGLE_BITS;
   localparam int WIDE_W = ANGLE_BITS + STEP_IN_W;

   // configuration registers
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [ELEV_W-1:0]   elev_min_ff, elev_min_in;
   logic [ELEV_W-1:0]   elev_max_ff, elev_max_in;

   // angle state
   logic [ANGLE_BITS-1:0] azimuth_ff, azimuth_in;
   logic [ELEV_W-1:0]     elevation_ff, elevation_in;
   logic                  upright_ff, upright_in;

   // sequencer
   state_type state_ff, state_in;

   // trig results and products
   logic signed [TRIG_W-1:0] sa_ff, ca_ff, se_ff, ce_ff;
   logic signed [TRIG_W-1:0] t_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [OFFSET_W-1:0] ox_ff, oy_ff;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OFFSET_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                       rsp_up_ff;

   // datapath signals
   logic                         accept;
   logic                         out_free;
   logic signed [WIDE_W-1:0]     step_wide;
   logic [ANGLE_BITS-1:0]        az_delta;
   logic signed [ELEV_SUM_W-1:0] elev_sum, elev_lo, elev_hi;
   logic [31:0]                  az_turn, el_turn;
   logic                         cordic_start;
   logic [31:0]                  cordic_turn;
   cordic_out_type               cordic_res;
   logic signed [TRIG_W-1:0]     mul_a, mul_b;
   logic                         mul_en;
   logic signed [PROD_W-1:0]     prod_rnd_sum;
   logic signed [TRIG_W-1:0]     prod_rnd;
   logic signed [OFFSET_W-1:0]   prod_sat;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------
   always_comb begin
      radius_in   = radius_ff;
      elev_min_in = elev_min_ff;
      elev_max_in = elev_max_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ORBIT_RADIUS:  radius_in   = csr_wdata;
            CSR_ELEVATION_MIN: elev_min_in = csr_wdata[ELEV_W-1:0];
            CSR_ELEVATION_MAX: elev_max_in = csr_wdata[ELEV_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Angle update, done in the accept cycle
   // ---------------------------------------------------------------
   always_comb begin
      // scale the step to the azimuth resolution (floor when narrowing)
      step_wide = WIDE_W'(req_azimuth_step);
      az_delta  = ANGLE_BITS'((step_wide <<< LSHIFT) >>> RSHIFT);

      elev_sum = signed'(ELEV_SUM_W'({1'b0, elevation_ff})) + ELEV_SUM_W'(req_elevation_step);
      elev_lo  = signed'(ELEV_SUM_W'({1'b0, elev_min_ff}));
      elev_hi  = signed'(ELEV_SUM_W'({1'b0, elev_max_ff}));

      azimuth_in   = azimuth_ff;
      elevation_in = elevation_ff;
      upright_in   = upright_ff;
      if (accept) begin
         // steer backward while upside down
         azimuth_in = upright_ff ? azimuth_ff + az_delta : azimuth_ff - az_delta;
         if (elev_sum < elev_lo) begin
            elevation_in = elev_min_ff;
         end else if (elev_sum > elev_hi) begin
            elevation_in = elev_max_ff;
         end else begin
            elevation_in = elev_sum[ELEV_W-1:0];
         end
         // clamped elevation never reaches half a turn, so only zero reads as down
         upright_in = (elevation_in != '0);
      end
   end

   assign az_turn = {azimuth_ff, {AZ_PAD{1'b0}}};
   assign el_turn = {1'b0, elevation_ff, 16'h0000};

   // ---------------------------------------------------------------
   // Shared CORDIC
   // ---------------------------------------------------------------
   orb_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .turn   (cordic_turn),
      .result (cordic_res)
   );

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_AZ_GO;
         ST_AZ_GO:   state_in = ST_AZ_WAIT;
         ST_AZ_WAIT: if (cordic_res.done) state_in = ST_EL_GO;
         ST_EL_GO:   state_in = ST_EL_WAIT;
         ST_EL_WAIT: if (cordic_res.done) state_in = ST_MUL_SA;
         ST_MUL_SA:  state_in = ST_MUL_RCE;
         ST_MUL_RCE: state_in = ST_MUL_SCA;
         ST_MUL_SCA: state_in = ST_MUL_RT1;
         ST_MUL_RT1: state_in = ST_MUL_RT2;
         ST_MUL_RT2: state_in = ST_FINISH;
         ST_FINISH:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs and multiplier operand select
   //   MUL_SA : se*sa
   //   MUL_RCE: r*ce,        t  <- round(se*sa)
   //   MUL_SCA: se*ca,       oy <- sat(round(r*ce))
   //   MUL_RT1: r*t (x),     t  <- round(se*ca)
   //   MUL_RT2: r*t (z),     ox <- sat(round(r*t))
   //   FINISH : oz <- sat(round(r*t)) straight into the output register
   // ---------------------------------------------------------------
   always_comb begin
      req_ready    = 1'b0;
      cordic_start = 1'b0;
      cordic_turn  = az_turn;
      mul_en       = 1'b0;
      mul_a        = se_ff;
      mul_b        = sa_ff;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_AZ_GO: cordic_start = 1'b1;
         ST_EL_GO: begin
            cordic_start = 1'b1;
            cordic_turn  = el_turn;
         end
         ST_MUL_SA: mul_en = 1'b1;
         ST_MUL_RCE: begin
            mul_en = 1'b1;
            mul_a  = signed'(TRIG_W'(radius_ff));
            mul_b  = ce_ff;
         end
         ST_MUL_SCA: begin
            mul_en = 1'b1;
            mul_b  = ca_ff;
         end
         ST_MUL_RT1, ST_MUL_RT2: begin
            mul_en = 1'b1;
            mul_a  = signed'(TRIG_W'(radius_ff));
            mul_b  = t_ff;
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // round half up to Q2.30 / Q8.8, then saturate for the offsets
   always_comb begin
      prod_rnd_sum = prod_ff + ROUND_HALF;
      prod_rnd     = signed'(prod_rnd_sum[61:30]);
      if (prod_rnd > OFFSET_LIMIT) begin
         prod_sat = OFFSET_W'(OFFSET_LIMIT);
      end else if (prod_rnd < -OFFSET_LIMIT) begin
         prod_sat = OFFSET_W'(-OFFSET_LIMIT);
      end else begin
         prod_sat = prod_rnd[OFFSET_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Control and state registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         elev_min_ff  <= ELEV_MIN_RESET;
         elev_max_ff  <= ELEV_MAX_RESET;
         azimuth_ff   <= '0;
         elevation_ff <= '0;
         upright_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         elev_min_ff  <= elev_min_in;
         elev_max_ff  <= elev_max_in;
         azimuth_ff   <= azimuth_in;
         elevation_ff <= elevation_in;
         upright_ff   <= upright_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_AZ_WAIT && cordic_res.done) begin
         sa_ff <= cordic_res.sin_q;
         ca_ff <= cordic_res.cos_q;
      end
      if (state_ff == ST_EL_WAIT && cordic_res.done) begin
         se_ff <= cordic_res.sin_q;
         ce_ff <= cordic_res.cos_q;
      end
      if (state_ff == ST_MUL_RCE || state_ff == ST_MUL_RT1) begin
         t_ff <= prod_rnd;
      end
      if (state_ff == ST_MUL_SCA) begin
         oy_ff <= prod_sat;
      end
      if (state_ff == ST_MUL_RT2) begin
         ox_ff <= prod_sat;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_x_ff  <= ox_ff;
         rsp_y_ff  <= oy_ff;
         rsp_z_ff  <= prod_sat;
         rsp_up_ff <= upright_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_offset_x   = rsp_x_ff;
   assign rsp_offset_y   = rsp_y_ff;
   assign rsp_offset_z   = rsp_z_ff;
   assign rsp_is_upright = rsp_up_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // elevation lands inside the limits, or on a limit when they are inverted
   a_elev_clamped: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((elevation_ff >= $past(elev_min_ff)) && (elevation_ff <= $past(elev_max_ff)))
                 || (elevation_ff == $past(elev_min_ff)) || (elevation_ff == $past(elev_max_ff)))
      else $error("elevation outside clamp limits");

   // up flag tracks a nonzero elevation after every step
   a_upright_flag: assert property (@(posedge clock) disable iff (reset)
      accept |=> (upright_ff == (elevation_ff != '0)))
      else $error("up flag disagrees with elevation");

   // CORDIC completes only while the sequencer waits for it
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cordic_res.done |-> (state_ff == ST_AZ_WAIT || state_ff == ST_EL_WAIT))
      else $error("CORDIC done outside a wait state");

   // a result appears only out of the finish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

   // no new word enters while the sequencer is busy
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_AZ_GO) && !req_ready)
      else $error("accept did not start the sequence");

endmodule

>>> tb/tb_orbit_angle_to_offset.sv
// tb_orbit_angle_to_offset: self-checking testbench of the orbit camera offset block.
// Drives angle-step words, predicts each offset word in place, checks them in order.
// Depends on orb_pkg and orbit_angle_to_offset.
`timescale 1ns / 100ps

module tb_orbit_angle_to_offset import orb_pkg::*; ();

   localparam int ANGLE_BITS      = 16;
   localparam int CORDIC_STEPS    = 16;
   localparam int ITEM_CYCLES     = 2 * CORDIC_STEPS + 11;
   localparam int END_CYCLES      = ITEM_CYCLES + 20;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 400;
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int REPORT_LIMIT    = 10;

   // one result word as the block returns it
   typedef struct packed {
      logic signed [OFFSET_W-1:0] x;
      logic signed [OFFSET_W-1:0] y;
      logic signed [OFFSET_W-1:0] z;
      logic                       up;
   } offset_word_type;

   typedef enum logic {
      ROW_CSR,
      ROW_ITEM
   } row_kind_type;

   // one line of the directed stimulus: a register write or an angle-step word,
   // the latter with an optional hand-written offset word to compare against
   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_INDEX_W-1:0]        index;
      logic [RADIUS_W-1:0]           value;
      logic signed [STEP_IN_W-1:0]   az;
      logic signed [STEP_IN_W-1:0]   el;
      logic                          typed;
      offset_word_type               want;
   } dir_row_type;

   function automatic dir_row_type row_item(input logic signed [STEP_IN_W-1:0] az,
                                            input logic signed [STEP_IN_W-1:0] el);
      dir_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.az = az;
      r.el = el;
      return r;
   endfunction

   function automatic dir_row_type row_check(input logic signed [STEP_IN_W-1:0] az,
                                             input logic signed [STEP_IN_W-1:0] el,
                                             input int x, input int y, input int z,
                                             input logic up);
      dir_row_type r;
      r = row_item(az, el);
      r.typed = 1'b1;
      r.want.x = x[OFFSET_W-1:0];
      r.want.y = y[OFFSET_W-1:0];
      r.want.z = z[OFFSET_W-1:0];
      r.want.up = up;
      return r;
   endfunction

   function automatic dir_row_type row_csr(input logic [CSR_INDEX_W-1:0] index,
                                           input logic [RADIUS_W-1:0] value);
      dir_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   // Directed stimulus. Offsets are typed in only where radius is zero, so every
   // product vanishes and only the up flag carries information.
   localparam int DIR_ROWS = 31;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // reset registers: elevation jumps to its lower clamp
      row_item(16'sd0, 16'sd0),
      // extremes of both steps
      row_item(16'sh7FFF, 16'sh7FFF),
      row_item(16'sh8000, 16'sh8000),
      row_item(16'sh4000, 16'sd0),
      row_item(-16'sd1, 16'sd1),
      row_item(16'sh5555, 16'shAAAA),
      row_item(16'shAAAA, 16'sh5555),
      // zero radius, zero elevation: camera flips down
      row_csr(CSR_ORBIT_RADIUS, 16'd0),
      row_csr(CSR_ELEVATION_MIN, 16'd0),
      row_csr(CSR_ELEVATION_MAX, 16'd0),
      row_check(16'sd100, 16'sd5, 0, 0, 0, 1'b0),
      row_check(16'sd100, -16'sd5, 0, 0, 0, 1'b0),
      // oversized writes: top bit of each elevation limit is dropped
      row_csr(CSR_ELEVATION_MIN, 16'hFFFF),
      row_csr(CSR_ELEVATION_MAX, 16'hFFFF),
      row_check(16'sd0, 16'sh8000, 0, 0, 0, 1'b1),
      // full radius with inverted limits: elevation lands on min or max
      row_csr(CSR_ORBIT_RADIUS, 16'hFFFF),
      row_csr(CSR_ELEVATION_MIN, 16'd16384),
      row_csr(CSR_ELEVATION_MAX, 16'd100),
      row_item(16'sd0, 16'sd1000),
      row_item(16'sd0, -16'sd200),
      row_item(16'sd12345, 16'sd0),
      // widest limits: drop to zero elevation, step azimuth while down, recover
      row_csr(CSR_ELEVATION_MIN, 16'd0),
      row_csr(CSR_ELEVATION_MAX, 16'h7FFF),
      row_item(16'sd0, 16'sh8000),
      row_item(16'sd8192, 16'sd0),
      row_item(-16'sd8192, 16'sd1),
      row_item(16'sh7FFF, 16'sh4000),
      row_item(16'sh8000, 16'sh3FFF),
      // unit radius
      row_csr(CSR_ORBIT_RADIUS, 16'd256),
      row_item(16'sd4096, -16'sd4096),
      row_item(16'sd0, 16'sd0)
   };

   logic                        clock;
   logic                        reset              = 1'b1;
   logic                        req_valid          = 1'b0;
   logic                        req_ready;
   logic signed [STEP_IN_W-1:0] req_azimuth_step   = '0;
   logic signed [STEP_IN_W-1:0] req_elevation_step = '0;
   logic                        rsp_valid;
   logic                        rsp_ready          = 1'b0;
   logic signed [OFFSET_W-1:0]  rsp_offset_x;
   logic signed [OFFSET_W-1:0]  rsp_offset_y;
   logic signed [OFFSET_W-1:0]  rsp_offset_z;
   logic                        rsp_is_upright;
   logic                        csr_write          = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index          = '0;
   logic [RADIUS_W-1:0]         csr_wdata          = '0;

   // camera state and register copies of the predictor
   logic [ANGLE_BITS-1:0]       cam_azimuth;
   int                          cam_elevation;
   logic                        cam_upright;
   logic [RADIUS_W-1:0]         radius_cfg;
   int                          elev_min_cfg;
   int                          elev_max_cfg;

   offset_word_type             pending_offsets [$];
   offset_word_type             seen_word;
   offset_word_type             oldest_word;
   int                          error_count   = 0;
   int                          report_count  = 0;
   int                          word_count    = 0;
   int                          stall_cycles  = 0;
   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;
   int                          hold_left     = 0;
   bit                          hold_request  = 1'b0;
   bit                          in_flight     = 1'b0;

   orbit_angle_to_offset #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_azimuth_step   (req_azimuth_step),
      .req_elevation_step (req_elevation_step),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_offset_x       (rsp_offset_x),
      .rsp_offset_y       (rsp_offset_y),
      .rsp_offset_z       (rsp_offset_z),
      .rsp_is_upright     (rsp_is_upright),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Rotation-mode CORDIC on a 2^32-per-turn angle: fold into +-quarter turn,
   // rotate, unfold, clamp both outputs to +-1.0 in Q2.30.
   function automatic void cordic_sin_cos(input logic [31:0] turn,
                                          output longint cos_v, output longint sin_v);
      longint  a, x, y, z, dx, dy, one, angle_step;
      rot_type rot;
      int      i;
      one = Q30_ONE;
      a = $signed(turn);
      rot = ROT_NONE;
      if (a > one) begin
         a = a - one;
         rot = ROT_POS;
      end else if (a < -one) begin
         a = a + one;
         rot = ROT_NEG;
      end
      x = CORDIC_START;
      y = 0;
      z = a;
      for (i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         angle_step = ATAN_TURNS[i];
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - angle_step;
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + angle_step;
         end
      end
      case (rot)
         ROT_POS: begin
            cos_v = -y;
            sin_v = x;
         end
         ROT_NEG: begin
            cos_v = y;
            sin_v = -x;
         end
         default: begin
            cos_v = x;
            sin_v = y;
         end
      endcase
      if (cos_v > one) cos_v = one;
      if (cos_v < -one) cos_v = -one;
      if (sin_v > one) sin_v = one;
      if (sin_v < -one) sin_v = -one;
   endfunction

   // round half up, then drop 30 fraction bits
   function automatic longint round_q30(input longint v);
      return (v + ROUND_HALF) >>> 30;
   endfunction

   function automatic logic signed [OFFSET_W-1:0] clip_offset(input longint v);
      longint lim;
      lim = OFFSET_LIMIT;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[OFFSET_W-1:0];
   endfunction

   // Advance the camera by one word and return the offset word it produces.
   function automatic offset_word_type advance_camera(
      input logic signed [STEP_IN_W-1:0] az_step,
      input logic signed [STEP_IN_W-1:0] el_step);
      longint          step, du, e, ca, sa, ce, se, r, t;
      logic [31:0]     az_turn, el_turn;
      offset_word_type w;
      step = az_step;
      if (ANGLE_BITS >= 16) du = step <<< (ANGLE_BITS - 16);
      else du = step >>> (16 - ANGLE_BITS);
      // flip the azimuth step while the camera is upside down
      if (cam_upright) cam_azimuth = cam_azimuth + du[ANGLE_BITS-1:0];
      else cam_azimuth = cam_azimuth - du[ANGLE_BITS-1:0];
      // the lower limit is tested first, so it wins when the limits are inverted and the sum lies below it
      e = cam_elevation + longint'(el_step);
      if (e < elev_min_cfg) e = elev_min_cfg;
      else if (e > elev_max_cfg) e = elev_max_cfg;
      cam_elevation = int'(e);
      cam_upright = (e > 0) && (e < 32768);
      az_turn = 32'(cam_azimuth) << (32 - ANGLE_BITS);
      el_turn = {cam_elevation[15:0], 16'h0000};
      cordic_sin_cos(az_turn, ca, sa);
      cordic_sin_cos(el_turn, ce, se);
      r = radius_cfg;
      t = round_q30(se * sa);
      w.x = clip_offset(round_q30(r * t));
      w.y = clip_offset(round_q30(r * ce));
      t = round_q30(se * ca);
      w.z = clip_offset(round_q30(r * t));
      w.up = cam_upright;
      return w;
   endfunction

   // Mix of small nudges, full-range steps and big swings toward the clamps.
   function automatic logic signed [STEP_IN_W-1:0] pick_angle_step();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(1024)) - 512;
         4, 5, 6:    v = int'($urandom());
         default: begin
            v = int'($urandom_range(32767, 16384));
            if ($urandom_range(1)) v = -v - 1;
         end
      endcase
      return v[STEP_IN_W-1:0];
   endfunction

   // Offer one word, idling first at the sender's rate; hold valid and the
   // payload until accepted, then queue the offset word it should produce.
   task automatic send_word(input logic signed [STEP_IN_W-1:0] az,
                            input logic signed [STEP_IN_W-1:0] el,
                            input logic typed, input offset_word_type want);
      offset_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_azimuth_step   <= az;
      req_elevation_step <= el;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = advance_camera(az, el);
      pending_offsets.push_back(typed ? want : predicted);
      in_flight = 1'b1;
   endtask

   // Drop valid and wait until every queued offset word has come back.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      in_flight = 1'b0;
   endtask

   // Write one register while the block is idle and mirror it in the predictor.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [RADIUS_W-1:0] value);
      if (in_flight) drain(SETTLE_CYCLES);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_ORBIT_RADIUS:  radius_cfg = value;
         CSR_ELEVATION_MIN: elev_min_cfg = int'(value[ELEV_W-1:0]);
         CSR_ELEVATION_MAX: elev_max_cfg = int'(value[ELEV_W-1:0]);
         default: ;
      endcase
   endtask

   // Receiver: take words at random, or hold off for a long stretch on request
   // so the block fills up and stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every accepted offset word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word.x  = rsp_offset_x;
         seen_word.y  = rsp_offset_y;
         seen_word.z  = rsp_offset_z;
         seen_word.up = rsp_is_upright;
         if (pending_offsets.size() == 0) begin
            error_count++;
            if (report_count < REPORT_LIMIT) begin
               report_count++;
               $display("unexpected offset word: x=%0d y=%0d z=%0d up=%0b",
                        seen_word.x, seen_word.y, seen_word.z, seen_word.up);
            end
         end else begin
            oldest_word = pending_offsets.pop_front();
            if (seen_word.x !== oldest_word.x || seen_word.y !== oldest_word.y ||
                seen_word.z !== oldest_word.z || seen_word.up !== oldest_word.up) begin
               error_count++;
               if (report_count < REPORT_LIMIT) begin
                  report_count++;
                  $display("offset word %0d: expected x=%0d y=%0d z=%0d up=%0b",
                           word_count, oldest_word.x, oldest_word.y, oldest_word.z,
                           oldest_word.up);
                  $display("offset word %0d: got      x=%0d y=%0d z=%0d up=%0b",
                           word_count, seen_word.x, seen_word.y, seen_word.z,
                           seen_word.up);
               end
            end
         end
         word_count++;
      end
   end

   // Watchdog: end the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_orbit_angle_to_offset: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int                  row, phase, n;
      logic [RADIUS_W-1:0] radius_pick, min_pick, max_pick;
      offset_word_type     no_word;
      no_word = '0;

      // predictor starts from the reset state of the block
      cam_azimuth   = '0;
      cam_elevation = 0;
      cam_upright   = 1'b1;
      radius_cfg    = RADIUS_RESET;
      elev_min_cfg  = int'(ELEV_MIN_RESET);
      elev_max_cfg  = int'(ELEV_MAX_RESET);

      // hold reset, then release it for good
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: sender idles a quarter of the time, receiver most of it
      send_idle_pct = 26;
      recv_idle_pct = 78;
      for (row = 0; row < DIR_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_CSR)
            write_register(DIRECTED[row].index, DIRECTED[row].value);
         else
            send_word(DIRECTED[row].az, DIRECTED[row].el, DIRECTED[row].typed,
                      DIRECTED[row].want);
      end

      // random phases, each with its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         // swap idle rates after the first two phases, then run flat out for the last two
         if (phase < 2) begin
            send_idle_pct = 26;
            recv_idle_pct = 78;
         end else if (phase < 4) begin
            send_idle_pct = 78;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: begin
               radius_pick = 16'hFFFF;
               min_pick    = 16'd0;
               max_pick    = 16'h7FFF;
            end
            1: begin
               radius_pick = RADIUS_W'($urandom_range(16'hFFFF));
               min_pick    = RADIUS_W'($urandom_range(16384));
               max_pick    = RADIUS_W'($urandom_range(32767));
            end
            2: begin
               radius_pick = RADIUS_W'($urandom_range(3000));
               min_pick    = 16'd0;
               max_pick    = RADIUS_W'($urandom_range(32767));
            end
            3: begin
               radius_pick = RADIUS_W'($urandom_range(16'hFFFF));
               min_pick    = 16'd16384;
               max_pick    = RADIUS_W'($urandom_range(16384));
            end
            4: begin
               radius_pick = 16'd256;
               min_pick    = RADIUS_W'($urandom_range(200));
               max_pick    = 16'h7FFF;
            end
            default: begin
               radius_pick = RADIUS_W'($urandom_range(16'hFFFF));
               min_pick    = RADIUS_W'($urandom_range(16384));
               max_pick    = RADIUS_W'($urandom_range(32767));
            end
         endcase
         // set the bit above each elevation limit at random; the block must drop it
         min_pick[15] = 1'($urandom_range(1));
         max_pick[15] = 1'($urandom_range(1));
         write_register(CSR_ORBIT_RADIUS, radius_pick);
         write_register(CSR_ELEVATION_MIN, min_pick);
         write_register(CSR_ELEVATION_MAX, max_pick);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // stall the receiver long enough for the block to back up
            if ((phase == 1 && n == 10) || (phase == 4 && n == 20)) hold_request = 1'b1;
            // pause the sender until everything in flight has come back
            if (phase == 3 && n == 100) drain(0);
            send_word(pick_angle_step(), pick_angle_step(), 1'b0, no_word);
         end
      end

      // wait out the last results and let the block settle
      drain(END_CYCLES);
      if (error_count == 0)
         $display("tb_orbit_angle_to_offset: done, clean");
      else
         $display("tb_orbit_angle_to_offset: done, errors");
      $finish;
   end

endmodule
